/* rtl/ctsp_pkg.sv */
package ctsp_pkg;

  // Position, fraction and time widths
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int TIME_W  = 16;

  localparam int MAG_W   = POS_W + 1;
  localparam int MUL_A_W = (MAG_W > FRAC_W + 1) ? MAG_W : FRAC_W + 1;
  localparam int MUL_B_W = FRAC_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CNT_W   = (FRAC_W > 1) ? $clog2(FRAC_W) : 1;
  localparam int AXES    = 3;
  localparam int AX_W    = 2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [TIME_W-1:0]       time_t;
  typedef logic [FRAC_W:0]         frac_t;

  localparam time_t TIME_MAX = '1;
  localparam frac_t ONE_Q    = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [1:0] {
    FUNC_FEEDBACK = 2'd0,
    FUNC_COMMAND  = 2'd1,
    FUNC_TICK     = 2'd2
  } func_e;

endpackage

/* rtl/cubic_trajectory_setpoint_top.sv */
// Three-axis smoothstep setpoint generator.
// Input channel (in_valid_i/in_ready_o): one word carries func_i, pos_*_i and
// duration_i. Feedback words store the current position, command words latch
// it as the start, store the target and duration, and restart the move. Tick
// words produce one setpoint word each; other codes are dropped.
// Output channel (out_valid_o/out_ready_i): set_*_o plus arrived_o.
// Tick path: once arrived, the goal goes straight to the output register;
// when elapsed equals the duration, u is one and the divider is skipped;
// else the restoring divider (one quotient bit per cycle) forms u. Then
// one shared multiplier forms u^2, u^3 and the three axis offsets.
// Feedback and command words leave the sequencer idle.
// in_ready_o is high only while the sequencer is idle, so one word is in
// work at a time. A finished setpoint waits in the output register; if the
// receiver stalls with an older setpoint still held, the sequencer waits in
// its last state until that one is taken. Nothing is dropped.
// Reset: positions clear to zero, duration to one, elapsed count saturated,
// so ticks after reset give the zero target with arrived_o set.
module cubic_trajectory_setpoint_top
  import ctsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [POS_W-1:0]  pos_z_i,
  input  logic [TIME_W-1:0] duration_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [POS_W-1:0]  set_x_o,
  output logic [POS_W-1:0]  set_y_o,
  output logic [POS_W-1:0]  set_z_o,
  output logic              arrived_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_SCALE,
    ST_BMUL,
    ST_BADD,
    ST_DONE
  } state_e;

  state_e state_q;

  // move state
  pos_t  cur_q   [AXES];
  pos_t  start_q [AXES];
  pos_t  goal_q  [AXES];
  mag_t  mag_q   [AXES];  // |goal - start|
  logic  neg_q   [AXES];  // goal below start
  time_t move_ticks_q;
  time_t elapsed_q;

  // work registers
  time_t                rem_q;
  frac_t                u_q;
  frac_t                u2_q;
  frac_t                s_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [AX_W-1:0]      ax_q;
  logic [PROD_W-1:0]    prod_q;
  pos_t                 res_q [AXES];
  logic                 arr_q;

  logic                 out_valid_q;
  pos_t                 set_q [AXES];
  logic                 arrived_q;

  logic                 in_acc;
  pos_t                 in_pos [AXES];
  mag_t                 cmd_mag [AXES];
  logic                 cmd_neg [AXES];

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;

  logic [TIME_W:0]      rem2;
  logic                 div_ge;
  time_t                rem_nx;
  frac_t                prod_hi;
  logic [FRAC_W+2:0]    s_wide;
  frac_t                s_clamp;
  pos_t                 off;
  pos_t                 blend;
  logic                 out_free;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_pos[0] = pos_x_i;
  assign in_pos[1] = pos_y_i;
  assign in_pos[2] = pos_z_i;

  // Command: difference magnitude and direction per axis, from two
  // parallel subtractors so only one carry chain sits in the path.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      cmd_neg[i] = in_pos[i] < cur_q[i];
      if (cmd_neg[i]) begin
        cmd_mag[i] = {cur_q[i][POS_W-1], cur_q[i]} - {in_pos[i][POS_W-1], in_pos[i]};
      end else begin
        cmd_mag[i] = {in_pos[i][POS_W-1], in_pos[i]} - {cur_q[i][POS_W-1], cur_q[i]};
      end
    end
  end

  // Divider step: remainder stays below move_ticks.
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, move_ticks_q};
  always_comb begin
    if (div_ge) begin
      rem_nx = TIME_W'(rem2 - {1'b0, move_ticks_q});
    end else begin
      rem_nx = rem2[TIME_W-1:0];
    end
  end

  // Shared multiplier
  assign prod_hi = prod_q[FRAC_W +: FRAC_W+1];

  always_comb begin
    case (state_q)
      ST_SQ: begin
        mul_a = MUL_A_W'(u_q);
        mul_b = u_q;
      end
      ST_CUBE: begin
        mul_a = MUL_A_W'(prod_hi);
        mul_b = u_q;
      end
      ST_BMUL: begin
        mul_a = MUL_A_W'(mag_q[ax_q]);
        mul_b = s_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // s = 3u^2 - 2u^3, at most one
  assign s_wide  = ({2'b00, u2_q} << 1) + {2'b00, u2_q} - ({2'b00, prod_hi} << 1);
  assign s_clamp = (s_wide > {2'b00, ONE_Q}) ? ONE_Q : s_wide[FRAC_W:0];

  assign off   = prod_q[FRAC_W +: POS_W];
  assign blend = neg_q[ax_q] ? (start_q[ax_q] - off) : (start_q[ax_q] + off);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int i = 0; i < AXES; i++) begin
        cur_q[i]   <= '0;
        start_q[i] <= '0;
        goal_q[i]  <= '0;
        mag_q[i]   <= '0;
        neg_q[i]   <= 1'b0;
        res_q[i]   <= '0;
        set_q[i]   <= '0;
      end
      move_ticks_q <= time_t'(1);
      elapsed_q    <= TIME_MAX;
      rem_q        <= '0;
      u_q          <= '0;
      u2_q         <= '0;
      s_q          <= '0;
      cnt_q        <= '0;
      ax_q         <= '0;
      prod_q       <= '0;
      arr_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      arrived_q    <= 1'b0;
    end else begin
      prod_q <= prod;
      // ST_DONE reloads the output register itself
      if (out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (func_i)
              FUNC_FEEDBACK: begin
                for (int i = 0; i < AXES; i++) cur_q[i] <= in_pos[i];
              end
              FUNC_COMMAND: begin
                for (int i = 0; i < AXES; i++) begin
                  start_q[i] <= cur_q[i];
                  goal_q[i]  <= in_pos[i];
                  mag_q[i]   <= cmd_mag[i];
                  neg_q[i]   <= cmd_neg[i];
                end
                move_ticks_q <= duration_i;
                elapsed_q    <= '0;
              end
              FUNC_TICK: begin
                if (elapsed_q != TIME_MAX) begin
                  elapsed_q <= elapsed_q + time_t'(1);
                end
                if (move_ticks_q == '0 || elapsed_q > move_ticks_q) begin
                  for (int i = 0; i < AXES; i++) res_q[i] <= goal_q[i];
                  arr_q   <= 1'b1;
                  state_q <= ST_DONE;
                end else if (elapsed_q == move_ticks_q) begin
                  u_q     <= ONE_Q;
                  state_q <= ST_SQ;
                end else begin
                  u_q     <= '0;
                  rem_q   <= elapsed_q;
                  cnt_q   <= CNT_W'(FRAC_W - 1);
                  state_q <= ST_DIV;
                end
              end
              default: ;  // unused code: dropped
            endcase
          end
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          u_q   <= {u_q[FRAC_W-1:0], div_ge};
          if (cnt_q == '0) begin
            state_q <= ST_SQ;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_SQ: begin
          state_q <= ST_CUBE;
        end
        ST_CUBE: begin
          u2_q    <= prod_hi;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          s_q     <= s_clamp;
          ax_q    <= '0;
          state_q <= ST_BMUL;
        end
        ST_BMUL: begin
          state_q <= ST_BADD;
        end
        ST_BADD: begin
          res_q[ax_q] <= blend;
          arr_q       <= 1'b0;
          if (ax_q == AX_W'(AXES - 1)) begin
            state_q <= ST_DONE;
          end else begin
            ax_q    <= ax_q + AX_W'(1);
            state_q <= ST_BMUL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            for (int i = 0; i < AXES; i++) set_q[i] <= res_q[i];
            arrived_q   <= arr_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign set_x_o     = set_q[0];
  assign set_y_o     = set_q[1];
  assign set_z_o     = set_q[2];
  assign arrived_o   = arrived_q;

endmodule

/* rtl/ctsp_checker.sv */
module ctsp_checker
  import ctsp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        func_i,
  input logic [POS_W-1:0]  pos_x_i,
  input logic [POS_W-1:0]  pos_y_i,
  input logic [POS_W-1:0]  pos_z_i,
  input logic [TIME_W-1:0] duration_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [POS_W-1:0]  set_x_o,
  input logic [POS_W-1:0]  set_y_o,
  input logic [POS_W-1:0]  set_z_o,
  input logic              arrived_o
);

  // held output word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(set_x_o) &&
    $stable(set_y_o) && $stable(set_z_o) && $stable(arrived_o))
    else $error("output word changed while stalled");

  // reset leaves the block idle with nothing to send
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("block not quiet in reset");

  // an accepted tick leaves the sequencer busy in the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_TICK |=> !in_ready_o)
    else $error("tick accepted without busy cycle");

  // feedback and command words leave the input ready and make no output word
  a_cmd_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_FEEDBACK || func_i == FUNC_COMMAND)
    |=> in_ready_o)
    else $error("control word stalled input");

  a_fb_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    (func_i == FUNC_FEEDBACK || func_i == FUNC_COMMAND) |=> !out_valid_o)
    else $error("output word from non-tick input");

endmodule

bind cubic_trajectory_setpoint_top ctsp_checker u_ctsp_checker (.*);
